/* design/slt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, constants and helpers of the script line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CHAR_WIDTH  = 16;
    localparam int COUNT_WIDTH = 8;
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    localparam logic [COUNT_WIDTH-1:0] MAX_TOKENS = 8'd255;

    localparam logic [CHAR_WIDTH-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB    = 16'h0009;
    localparam logic [CHAR_WIDTH-1:0] CH_SEMI   = 16'h003B;
    localparam logic [CHAR_WIDTH-1:0] CH_HASH   = 16'h0023;
    localparam logic [CHAR_WIDTH-1:0] CH_DOLLAR = 16'h0024;
    localparam logic [CHAR_WIDTH-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CHAR_WIDTH-1:0] CH_BTICK  = 16'h0060;
    localparam logic [CHAR_WIDTH-1:0] CH_SQUOTE = 16'h0027;
    localparam logic [CHAR_WIDTH-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [CHAR_WIDTH-1:0] CH_SLASH  = 16'h002F;
    localparam logic [CHAR_WIDTH-1:0] CH_STAR   = 16'h002A;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        QK_NONE   = 2'd0,
        QK_DOUBLE = 2'd1,
        QK_SINGLE = 2'd2,
        QK_BTICK  = 2'd3
    } quote_kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CHAR_WIDTH-1:0]  out_char;
        logic [COUNT_WIDTH-1:0] token_index;
        logic                   error;
        logic                   comment_seen;
        logic                   block_open;
        logic [COUNT_WIDTH-1:0] token_count;
        logic                   last;
    } slt_result_t;

    // results of one item, handed from the step logic to the result buffer
    typedef struct packed {
        slt_result_t [MAX_RESULTS-1:0] res;
        logic [RES_CNT_W-1:0]          count;
    } slt_batch_t;

    function automatic logic is_sep(input logic [CHAR_WIDTH-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_quote(input logic [CHAR_WIDTH-1:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_BTICK);
    endfunction

    function automatic quote_kind_t quote_kind_of(input logic [CHAR_WIDTH-1:0] c);
        quote_kind_t q;
        if (c == CH_DQUOTE)
            q = QK_DOUBLE;
        else if (c == CH_SQUOTE)
            q = QK_SINGLE;
        else
            q = QK_BTICK;
        return q;
    endfunction

    function automatic logic ends_token(input logic [CHAR_WIDTH-1:0] c,
                                        input quote_kind_t q);
        logic e;
        unique case (q)
            QK_NONE:   e = is_sep(c);
            QK_DOUBLE: e = (c == CH_DQUOTE);
            QK_SINGLE: e = (c == CH_SQUOTE);
            QK_BTICK:  e = (c == CH_BTICK);
        endcase
        return e;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v < MAX_TOKENS) ? v + 1'b1 : v;
    endfunction

    function automatic slt_result_t mk_result(input kind_t k,
                                              input logic [CHAR_WIDTH-1:0] c,
                                              input logic [COUNT_WIDTH-1:0] tidx);
        slt_result_t r;
        r             = '0;
        r.kind        = k;
        r.out_char    = c;
        r.token_index = tidx;
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/slt_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slt_step
// Tokenizer state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module slt_step (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          process,
    input  wire  [slt_pkg::CHAR_WIDTH-1:0] ch,
    input  wire                          end_of_line,
    input  wire                          keep_escapes,
    output slt_pkg::slt_batch_t          batch
);
    import slt_pkg::*;

    typedef enum logic [1:0] {
        MODE_SKIP    = 2'd0,
        MODE_SLASH   = 2'd1,
        MODE_TOKEN   = 2'd2,
        MODE_COMMENT = 2'd3
    } mode_t;

    mode_t                  mode_reg,  mode_next;
    quote_kind_t            quote_reg, quote_next;
    logic [1:0]             held_reg,  held_next;
    logic                   star_reg,  star_next;
    logic                   block_reg, block_next;
    logic                   lcom_reg,  lcom_next;
    logic                   qerr_reg,  qerr_next;
    logic [COUNT_WIDTH-1:0] tok_reg,   tok_next;

    slt_result_t [MAX_RESULTS-1:0] r;
    logic [RES_CNT_W-1:0]          n;
    logic                          do_plain;
    slt_result_t                   le;

    // held characters are always dollar then backslash, so only the count is kept
    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        held_next  = held_reg;
        star_next  = star_reg;
        block_next = block_reg;
        lcom_next  = lcom_reg;
        qerr_next  = qerr_reg;
        tok_next   = tok_reg;
        r          = '0;
        n          = '0;
        do_plain   = 1'b0;
        le         = '0;

        if (end_of_line)
        begin
            if (!block_next)
            begin
                if (mode_next == MODE_SLASH)
                begin
                    r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, CH_SLASH, tok_next);
                    n = n + 1'b1;
                    r[n[RES_IDX_W-1:0]] = mk_result(KIND_TOKEN_END, '0, tok_next);
                    n = n + 1'b1;
                    tok_next = sat_inc(tok_next);
                end
                else if (mode_next == MODE_TOKEN)
                begin
                    if (held_next != 2'd0)
                    begin
                        r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, CH_DOLLAR, tok_next);
                        n = n + 1'b1;
                    end
                    if (held_next == 2'd2)
                    begin
                        r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, CH_BSLASH, tok_next);
                        n = n + 1'b1;
                    end
                    if (quote_next != QK_NONE)
                        qerr_next = 1'b1;
                    r[n[RES_IDX_W-1:0]] = mk_result(KIND_TOKEN_END, '0, tok_next);
                    n = n + 1'b1;
                    tok_next = sat_inc(tok_next);
                end
            end
            le              = mk_result(KIND_LINE_END, '0, tok_next);
            le.error        = qerr_next;
            le.comment_seen = lcom_next;
            le.block_open   = block_next;
            le.token_count  = tok_next;
            r[n[RES_IDX_W-1:0]] = le;
            n = n + 1'b1;
            mode_next  = MODE_SKIP;
            quote_next = QK_NONE;
            held_next  = 2'd0;
            star_next  = 1'b0;
            tok_next   = '0;
            lcom_next  = 1'b0;
            qerr_next  = 1'b0;
        end
        else if (block_next)
        begin
            if (star_next && (ch == CH_SLASH))
            begin
                block_next = 1'b0;
                star_next  = 1'b0;
                mode_next  = MODE_SKIP;
            end
            else
                star_next = (ch == CH_STAR);
        end
        else
        begin
            unique case (mode_next)
                MODE_SKIP:
                begin
                    if (is_sep(ch))
                        mode_next = MODE_SKIP;
                    else if ((ch == CH_SEMI) || (ch == CH_HASH))
                    begin
                        mode_next = MODE_COMMENT;
                        lcom_next = 1'b1;
                    end
                    else if (ch == CH_SLASH)
                        mode_next = MODE_SLASH;
                    else if (is_quote(ch))
                    begin
                        mode_next  = MODE_TOKEN;
                        quote_next = quote_kind_of(ch);
                        held_next  = 2'd0;
                    end
                    else
                    begin
                        mode_next  = MODE_TOKEN;
                        quote_next = QK_NONE;
                        held_next  = 2'd0;
                        do_plain   = 1'b1;
                    end
                end
                MODE_SLASH:
                begin
                    if (ch == CH_STAR)
                    begin
                        block_next = 1'b1;
                        star_next  = 1'b0;
                        mode_next  = MODE_SKIP;
                    end
                    else
                    begin
                        mode_next  = MODE_TOKEN;
                        quote_next = QK_NONE;
                        held_next  = 2'd0;
                        r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, CH_SLASH, tok_next);
                        n = n + 1'b1;
                        do_plain = 1'b1;
                    end
                end
                MODE_TOKEN:
                begin
                    if (held_next == 2'd1)
                    begin
                        if (ch == CH_BSLASH)
                            held_next = 2'd2;
                        else
                        begin
                            held_next = 2'd0;
                            r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, CH_DOLLAR, tok_next);
                            n = n + 1'b1;
                            do_plain = 1'b1;
                        end
                    end
                    else if (held_next == 2'd2)
                    begin
                        held_next = 2'd0;
                        // escape beats a closing quote
                        if (!is_quote(ch) || keep_escapes)
                        begin
                            r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, CH_DOLLAR, tok_next);
                            n = n + 1'b1;
                            r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, CH_BSLASH, tok_next);
                            n = n + 1'b1;
                        end
                        if (is_quote(ch))
                        begin
                            r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, ch, tok_next);
                            n = n + 1'b1;
                        end
                        else
                            do_plain = 1'b1;
                    end
                    else
                        do_plain = 1'b1;
                end
                MODE_COMMENT:
                    mode_next = MODE_COMMENT;
            endcase
        end

        // ordinary character inside a token
        if (do_plain)
        begin
            if (ch == CH_DOLLAR)
                held_next = 2'd1;
            else if (ends_token(ch, quote_next))
            begin
                r[n[RES_IDX_W-1:0]] = mk_result(KIND_TOKEN_END, '0, tok_next);
                n = n + 1'b1;
                tok_next   = sat_inc(tok_next);
                mode_next  = MODE_SKIP;
                quote_next = QK_NONE;
                held_next  = 2'd0;
            end
            else
            begin
                r[n[RES_IDX_W-1:0]] = mk_result(KIND_CHAR, ch, tok_next);
                n = n + 1'b1;
            end
        end

        if (n != '0)
            r[n[RES_IDX_W-1:0] - 1'b1].last = 1'b1;

        batch.res   = r;
        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SKIP;
            quote_reg <= QK_NONE;
            held_reg  <= 2'd0;
            star_reg  <= 1'b0;
            block_reg <= 1'b0;
            lcom_reg  <= 1'b0;
            qerr_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else if (process)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            held_reg  <= held_next;
            star_reg  <= star_next;
            block_reg <= block_next;
            lcom_reg  <= lcom_next;
            qerr_reg  <= qerr_next;
            tok_reg   <= tok_next;
        end
    end

endmodule
`default_nettype wire

/* design/slt_result_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slt_result_buf
// Holds the results of one item and hands them out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module slt_result_buf (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  load,
    input  wire slt_pkg::slt_batch_t batch,
    output logic                 free,
    output logic                 out_valid,
    input  wire                  out_stall,
    output slt_pkg::slt_result_t out_res
);
    import slt_pkg::*;

    slt_result_t [MAX_RESULTS-1:0] entry_reg;
    logic [RES_CNT_W-1:0]          count_reg;
    logic [RES_IDX_W-1:0]          rd_reg;
    logic                          take;

    assign out_valid = (count_reg != '0);
    assign take      = out_valid && !out_stall;
    // room for the next item once the final waiting result leaves
    assign free      = (count_reg == '0) || ((count_reg == RES_CNT_W'(1)) && take);
    assign out_res   = entry_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= '0;
        end
        else if (load)
        begin
            count_reg <= batch.count;
            rd_reg    <= '0;
        end
        else if (take)
        begin
            count_reg <= count_reg - 1'b1;
            rd_reg    <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            entry_reg <= batch.res;
    end

endmodule
`default_nettype wire

/* design/script_line_tokenizer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// script_line_tokenizer_top
// Splits script lines into tokens, comments and line summaries.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with ch and end_of_line. Each item is a
// character or an end-of-line marker.
// Output channel: out_valid / out_stall with kind, out_char, token_index and
// the line summary fields; last marks the final result of an item.
// Configuration: cfg_valid / cfg_ready with cfg_data sets keep_escapes; the
// port is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. An accepted item is held in the
// input register, decoded by the step logic once the result buffer is free,
// and loaded into the result buffer, whose output gives its first result.
// Throughput: one item per cycle while items give at most one result and the
// output is not stalled. An item with more results (up to four) holds the
// result buffer until all have left, one result per cycle while unstalled.
// A stall on the output holds the current result; the input register then
// fills and in_stall rises until the buffer frees.
// Reset clears the tokenizer state, keep_escapes and the valid state of both register stages.
// ----------------------------------------------------------------------------
module script_line_tokenizer_top (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire  [slt_pkg::CHAR_WIDTH-1:0]  ch,
    input  wire                            end_of_line,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [1:0]                     kind,
    output logic [slt_pkg::CHAR_WIDTH-1:0] out_char,
    output logic [slt_pkg::COUNT_WIDTH-1:0] token_index,
    output logic                           error,
    output logic                           comment_seen,
    output logic                           block_open,
    output logic [slt_pkg::COUNT_WIDTH-1:0] token_count,
    output logic                           last,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire                            cfg_data
);
    import slt_pkg::*;

    logic                  in_valid_reg;
    logic [CHAR_WIDTH-1:0] ch_reg;
    logic                  eol_reg;
    logic                  keep_reg;
    logic                  buf_free;
    logic                  process;
    slt_batch_t            batch;
    slt_result_t           res;

    assign cfg_ready = 1'b1;
    assign process   = in_valid_reg && buf_free;
    assign in_stall  = in_valid_reg && !buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            keep_reg     <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                in_valid_reg <= 1'b1;
            else if (process)
                in_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                keep_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg  <= ch;
            eol_reg <= end_of_line;
        end
    end

    slt_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .process      (process),
        .ch           (ch_reg),
        .end_of_line  (eol_reg),
        .keep_escapes (keep_reg),
        .batch        (batch)
    );

    slt_result_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (process),
        .batch     (batch),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res)
    );

    assign kind         = res.kind;
    assign out_char     = res.out_char;
    assign token_index  = res.token_index;
    assign error        = res.error;
    assign comment_seen = res.comment_seen;
    assign block_open   = res.block_open;
    assign token_count  = res.token_count;
    assign last         = res.last;

endmodule
`default_nettype wire

/* design/slt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks of the tokenizer output, bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             out_valid,
    input  wire                             out_stall,
    input  wire  [1:0]                      kind,
    input  wire  [slt_pkg::CHAR_WIDTH-1:0]  out_char,
    input  wire  [slt_pkg::COUNT_WIDTH-1:0] token_index,
    input  wire                             error,
    input  wire                             comment_seen,
    input  wire                             block_open,
    input  wire  [slt_pkg::COUNT_WIDTH-1:0] token_count,
    input  wire                             last
);
    import slt_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_char)
            && $stable(token_index) && $stable(last) && $stable(token_count))
        else $error("stalled result changed");

    // a line end closes the item that caused it
    a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_LINE_END) |-> last)
        else $error("line end not marked last");

    // summary fields only on line ends
    a_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_LINE_END) |->
            !error && !comment_seen && !block_open && (token_count == '0))
        else $error("summary field set outside line end");

    // line summary count matches the reported index
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_LINE_END) |-> (token_count == token_index))
        else $error("line end count and index differ");

    // token ends carry no character
    a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_TOKEN_END) |-> (out_char == '0))
        else $error("token end with character");

endmodule

bind script_line_tokenizer_top slt_checker u_slt_checker (.*);
`default_nettype wire
